FILE: hw/rtl/flts_pkg.sv
// shared types and constants of the frame light trigger sequencer
package flts_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 32;

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 1;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W    = 8;
    localparam int SLOT_W    = 5;
    localparam int CNT_W     = 16;

    typedef enum logic [3:0] {
        CMD_FRAME_BEGIN = 4'd0,
        CMD_FRAME_END   = 4'd1,
        CMD_LED_ON      = 4'd2,
        CMD_STIM_TICK   = 4'd3,
        CMD_STROBE      = 4'd4,
        CMD_WRITE_STEP  = 4'd5,
        CMD_START       = 4'd6,
        CMD_STOP        = 4'd7,
        CMD_STIM_STOP   = 4'd8
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEQ_LEN      = 3'd0,
        CFG_OUT0_MODE    = 3'd1,
        CFG_OUT1_MODE    = 3'd2,
        CFG_EVENT_SRC    = 3'd3,
        CFG_STIM_ON      = 3'd4,
        CFG_STIM_PERIOD  = 3'd5,
        CFG_STIM_REPEATS = 3'd6
    } cfg_idx_t;

    localparam logic [1:0] OUT_MODE_OTHER  = 2'd0;
    localparam logic [1:0] OUT_MODE_STROBE = 2'd1;
    localparam logic [1:0] OUT_MODE_TABLE  = 2'd2;
    localparam logic [1:0] OUT_MODE_CAMERA = 2'd3;

    localparam logic [1:0] EVT_SRC_NONE   = 2'd0;
    localparam logic [1:0] EVT_SRC_STROBE = 2'd1;
    localparam logic [1:0] EVT_SRC_FRAME  = 2'd2;

    localparam logic [5:0]       RST_SEQ_LEN     = 6'd1;
    localparam logic [CNT_W-1:0] RST_STIM_ON     = 16'd10;
    localparam logic [CNT_W-1:0] RST_STIM_PERIOD = 16'd100;
    localparam logic [CNT_W-1:0] RST_STIM_REPS   = 16'd0;

    localparam int BIT_EXTRA = 3;
    localparam int BIT_OUT0  = 4;
    localparam int BIT_OUT1  = 5;
    localparam int BIT_STIM  = 6;

endpackage

FILE: hw/rtl/flts_ram.sv
// generic single-write, single-read ram with registered read data
module flts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/frame_light_trigger_sequencer_unit.sv
// top level of the frame light trigger sequencer
//
// s_ channel: one event item per handshake, the command in s_tuser and its
// operands in s_tdata. m_ channel: one result item per input item, the
// output levels after the event and an optional frame event word, flagged
// by m_tuser. cfg_ port: plain register writes; the user must make them only
// while idle, the block itself does not enforce it. An item passes an input
// register, then the state update that fills the result register.
// Throughput is one item per cycle unless m_tready stalls the output; the
// loop that sets it is the state update, which reads the light table through
// a ram whose registered read is addressed by the next step index, with a
// bypass for a same-cycle write. Reset (aresetn low, synchronous) clears the
// sequencer, the stimulation train, the outputs and the registers to their
// defaults; the light table keeps no reset and must be written before use.
// When m_tready is held low the result stays on m_tdata, one more item is held
// in the input register and s_tready then drops until the result is taken.
module frame_light_trigger_sequencer_unit
    import flts_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // strobe_level, in_level, step_slot[4:0], step_value[7:0], zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // cmd[3:0]
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // led_levels[2:0], extra_level, out0_level, out1_level, stim_active,
    // event_word[7:0], zero pad
    output logic [M_TDATA_W-1:0] m_tdata,
    // event_valid
    output logic [M_TUSER_W-1:0] m_tuser,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam logic [8:0] DEPTH9 = 9'(TABLE_DEPTH);

    // input register
    logic                 in_valid_reg;
    logic [S_TDATA_W-1:0] in_data_reg;
    logic [S_TUSER_W-1:0] in_user_reg;

    // configuration
    logic [5:0]       seq_len_reg;
    logic [1:0]       out0_mode_reg, out1_mode_reg, evt_src_reg;
    logic [CNT_W-1:0] stim_on_ticks_reg, stim_period_ticks_reg, stim_repeats_reg;

    // sequencer and output state
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             run_reg, run_next;
    logic             skip_reg, skip_next;
    logic             stop_reg, stop_next;
    logic [2:0]       led_reg, led_next;
    logic             extra_reg, extra_next;
    logic             out0_reg, out0_next;
    logic             out1_reg, out1_next;
    logic             stim_run_reg, stim_run_next;
    logic             stim_stop_reg, stim_stop_next;
    logic [CNT_W-1:0] on_cnt_reg, on_cnt_next;
    logic [CNT_W-1:0] per_cnt_reg, per_cnt_next;
    logic [CNT_W-1:0] rep_cnt_reg, rep_cnt_next;

    // result register
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic                 m_event_reg;

    // table access
    logic              fwd_hit_reg;
    logic [STEP_W-1:0] fwd_data_reg;
    logic [STEP_W-1:0] ram_rdata;
    logic [STEP_W-1:0] entry;
    logic              tbl_we;
    logic [IDX_W-1:0]  tbl_waddr;

    // decoded fields
    logic              advance;
    cmd_t              cmd;
    logic              strobe;
    logic              in_level;
    logic [SLOT_W-1:0] slot;
    logic [8:0]        slot9;
    logic [STEP_W-1:0] value;
    logic [8:0]        len;
    logic [8:0]        idx_inc;
    logic [CNT_W-1:0]  on_inc, per_inc, rep_inc;
    logic              ev;
    logic [7:0]        event_word;

    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign cmd      = cmd_t'(in_user_reg[3:0]);
    assign strobe   = in_data_reg[0];
    assign in_level = in_data_reg[1];
    assign slot     = in_data_reg[6:2];
    assign value    = in_data_reg[14:7];
    assign slot9    = 9'(slot);

    assign entry   = fwd_hit_reg ? fwd_data_reg : ram_rdata;
    assign idx_inc = 9'(idx_reg) + 9'd1;
    assign on_inc  = on_cnt_reg + 16'd1;
    assign per_inc = per_cnt_reg + 16'd1;
    assign rep_inc = rep_cnt_reg + 16'd1;

    assign tbl_we    = advance && (cmd == CMD_WRITE_STEP) && (slot9 < DEPTH9);
    assign tbl_waddr = slot9[IDX_W-1:0];

    always_comb begin
        if (seq_len_reg == 6'd0) begin
            len = 9'd1;
        end else if (9'(seq_len_reg) > DEPTH9) begin
            len = DEPTH9;
        end else begin
            len = 9'(seq_len_reg);
        end
    end

    always_comb begin
        idx_next       = idx_reg;
        run_next       = run_reg;
        skip_next      = skip_reg;
        stop_next      = stop_reg;
        led_next       = led_reg;
        extra_next     = extra_reg;
        out0_next      = out0_reg;
        out1_next      = out1_reg;
        stim_run_next  = stim_run_reg;
        stim_stop_next = stim_stop_reg;
        on_cnt_next    = on_cnt_reg;
        per_cnt_next   = per_cnt_reg;
        rep_cnt_next   = rep_cnt_reg;
        ev             = 1'b0;
        if (advance) begin
            unique case (cmd)
                CMD_FRAME_BEGIN: begin
                    if (run_reg) begin
                        if (skip_reg) begin
                            skip_next = 1'b0;
                        end else begin
                            idx_next = (idx_inc >= len) ? '0 : idx_inc[IDX_W-1:0];
                            if (stim_repeats_reg == '0) begin
                                extra_next = entry[BIT_EXTRA];
                            end
                            if (out0_mode_reg == OUT_MODE_TABLE) begin
                                out0_next = entry[BIT_OUT0];
                            end
                            if (out1_mode_reg == OUT_MODE_TABLE) begin
                                out1_next = entry[BIT_OUT1];
                            end
                            if (entry[BIT_STIM] && !stim_run_reg) begin
                                stim_run_next  = 1'b1;
                                stim_stop_next = 1'b0;
                                on_cnt_next    = '0;
                                per_cnt_next   = '0;
                                rep_cnt_next   = '0;
                                extra_next     = 1'b1;
                            end
                            if (out0_mode_reg == OUT_MODE_CAMERA) begin
                                out0_next = 1'b1;
                            end
                            if (out1_mode_reg == OUT_MODE_CAMERA) begin
                                out1_next = 1'b1;
                            end
                            ev = (evt_src_reg == EVT_SRC_FRAME);
                        end
                    end
                end
                CMD_FRAME_END: begin
                    if (run_reg) begin
                        led_next = '0;
                        if (stim_repeats_reg == '0) begin
                            extra_next = 1'b0;
                        end
                        if (out0_mode_reg == OUT_MODE_CAMERA) begin
                            out0_next = 1'b0;
                        end
                        if (out1_mode_reg == OUT_MODE_CAMERA) begin
                            out1_next = 1'b0;
                        end
                        if (stop_reg) begin
                            stop_next = 1'b0;
                            run_next  = 1'b0;
                            if (out0_mode_reg == OUT_MODE_TABLE) begin
                                out0_next = 1'b0;
                            end
                            if (out1_mode_reg == OUT_MODE_TABLE) begin
                                out1_next = 1'b0;
                            end
                        end
                    end
                end
                CMD_LED_ON: begin
                    if (run_reg) begin
                        led_next = led_reg | entry[2:0];
                    end
                end
                CMD_STIM_TICK: begin
                    if (stim_run_reg) begin
                        if (extra_reg) begin
                            on_cnt_next = on_inc;
                            if (on_inc == stim_on_ticks_reg) begin
                                on_cnt_next = '0;
                                extra_next  = 1'b0;
                            end
                        end
                        per_cnt_next = per_inc;
                        if (per_inc == stim_period_ticks_reg) begin
                            rep_cnt_next = rep_inc;
                            if (rep_inc == stim_repeats_reg || stim_stop_reg) begin
                                stim_run_next  = 1'b0;
                                stim_stop_next = 1'b0;
                            end else begin
                                per_cnt_next = '0;
                                extra_next   = 1'b1;
                            end
                        end
                    end
                end
                CMD_STROBE: begin
                    if (out0_mode_reg == OUT_MODE_STROBE) begin
                        out0_next = strobe;
                    end
                    if (out1_mode_reg == OUT_MODE_STROBE) begin
                        out1_next = strobe;
                    end
                    ev = strobe && (evt_src_reg == EVT_SRC_STROBE);
                end
                CMD_START: begin
                    if (!run_reg) begin
                        run_next  = 1'b1;
                        idx_next  = '0;
                        skip_next = 1'b1;
                        stop_next = 1'b0;
                    end
                end
                CMD_STOP: begin
                    if (run_reg) begin
                        stop_next = 1'b1;
                    end
                end
                CMD_STIM_STOP: begin
                    if (stim_run_reg) begin
                        stim_stop_next = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign event_word = ev ? {in_level, stim_run_next, out1_next, out0_next, extra_next,
                              led_next} : 8'd0;

    flts_ram #(
        .WIDTH(STEP_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .aclk (aclk),
        .we   (tbl_we),
        .waddr(tbl_waddr),
        .wdata(value),
        .raddr(idx_next),
        .rdata(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        fwd_data_reg <= value;
        if (!aresetn) begin
            fwd_hit_reg <= 1'b0;
        end else begin
            fwd_hit_reg <= tbl_we && (tbl_waddr == idx_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_len_reg           <= RST_SEQ_LEN;
            out0_mode_reg         <= OUT_MODE_OTHER;
            out1_mode_reg         <= OUT_MODE_OTHER;
            evt_src_reg           <= EVT_SRC_NONE;
            stim_on_ticks_reg     <= RST_STIM_ON;
            stim_period_ticks_reg <= RST_STIM_PERIOD;
            stim_repeats_reg      <= RST_STIM_REPS;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SEQ_LEN:      seq_len_reg           <= cfg_wdata[5:0];
                CFG_OUT0_MODE:    out0_mode_reg         <= cfg_wdata[1:0];
                CFG_OUT1_MODE:    out1_mode_reg         <= cfg_wdata[1:0];
                CFG_EVENT_SRC:    evt_src_reg           <= cfg_wdata[1:0];
                CFG_STIM_ON:      stim_on_ticks_reg     <= cfg_wdata;
                CFG_STIM_PERIOD:  stim_period_ticks_reg <= cfg_wdata;
                CFG_STIM_REPEATS: stim_repeats_reg      <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_user_reg <= s_tuser;
        end
        if (advance) begin
            m_data_reg  <= {1'b0, event_word, stim_run_next, out1_next, out0_next,
                            extra_next, led_next};
            m_event_reg <= ev;
        end
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            run_reg       <= 1'b0;
            skip_reg      <= 1'b0;
            stop_reg      <= 1'b0;
            led_reg       <= '0;
            extra_reg     <= 1'b0;
            out0_reg      <= 1'b0;
            out1_reg      <= 1'b0;
            stim_run_reg  <= 1'b0;
            stim_stop_reg <= 1'b0;
            on_cnt_reg    <= '0;
            per_cnt_reg   <= '0;
            rep_cnt_reg   <= '0;
        end else begin
            idx_reg       <= idx_next;
            run_reg       <= run_next;
            skip_reg      <= skip_next;
            stop_reg      <= stop_next;
            led_reg       <= led_next;
            extra_reg     <= extra_next;
            out0_reg      <= out0_next;
            out1_reg      <= out1_next;
            stim_run_reg  <= stim_run_next;
            stim_stop_reg <= stim_stop_next;
            on_cnt_reg    <= on_cnt_next;
            per_cnt_reg   <= per_cnt_next;
            rep_cnt_reg   <= rep_cnt_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_event_reg;

endmodule

FILE: hw/rtl/flts_checker.sv
// port-level checks of the sequencer and their binding to the top level
module flts_checker
    import flts_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    // nothing comes out in the cycle after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // a ready receiver never blocks the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output is free");

    // event word is zero without an event and mirrors the levels with one
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[14:7] == 8'd0)
        else $error("event word set without event");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[13:7] == m_tdata[6:0])
        else $error("event word disagrees with levels");

endmodule

bind frame_light_trigger_sequencer_unit flts_checker u_flts_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);

FILE: tb/sv/frame_light_trigger_sequencer_unit_tb.sv
// testbench for the frame light trigger sequencer: random event traffic against a predictor
`timescale 1ns / 1ps

module frame_light_trigger_sequencer_unit_tb
    import flts_pkg::*;
();

    localparam int LIGHT_DEPTH = DEFAULT_TABLE_DEPTH;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD = 400;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 205;
    localparam logic [3:0] CMD_UNUSED_LO = 4'd9;
    localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

    typedef struct packed {
        logic [2:0] leds;
        logic       extra;
        logic       out0;
        logic       out1;
        logic       stim;
        logic       ev;
        logic [7:0] word;
    } light_levels_t;

    class light_scoreboard;
        logic [7:0]    lights [LIGHT_DEPTH];
        int            step_idx;
        bit            running, skip_frame, stop_pend;
        logic [2:0]    leds;
        bit            extra, out0, out1;
        bit            stim_run, stim_stop_pend;
        logic [15:0]   on_cnt, per_cnt, rep_cnt;
        logic [5:0]    seq_len;
        logic [1:0]    out0_mode, out1_mode, evt_src;
        logic [15:0]   on_ticks, per_ticks, reps;
        light_levels_t levels_q [$];
        int            errors;

        function new();
            foreach (lights[i]) lights[i] = '0;
            step_idx = 0;
            running = 0; skip_frame = 0; stop_pend = 0;
            leds = '0; extra = 0; out0 = 0; out1 = 0;
            stim_run = 0; stim_stop_pend = 0;
            on_cnt = '0; per_cnt = '0; rep_cnt = '0;
            seq_len = RST_SEQ_LEN;
            out0_mode = OUT_MODE_OTHER; out1_mode = OUT_MODE_OTHER;
            evt_src = EVT_SRC_NONE;
            on_ticks = RST_STIM_ON; per_ticks = RST_STIM_PERIOD; reps = RST_STIM_REPS;
            errors = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [15:0] val);
            case (idx)
                CFG_SEQ_LEN:      seq_len = val[5:0];
                CFG_OUT0_MODE:    out0_mode = val[1:0];
                CFG_OUT1_MODE:    out1_mode = val[1:0];
                CFG_EVENT_SRC:    evt_src = val[1:0];
                CFG_STIM_ON:      on_ticks = val;
                CFG_STIM_PERIOD:  per_ticks = val;
                CFG_STIM_REPEATS: reps = val;
                default: ;
            endcase
        endfunction

        function void start_train();
            if (!stim_run) begin
                stim_run = 1; stim_stop_pend = 0;
                on_cnt = '0; per_cnt = '0; rep_cnt = '0;
                extra = 1;
            end
        endfunction

        function void note_item(logic [3:0] cmd, logic strobe, logic lvl,
                                logic [4:0] slot, logic [7:0] val);
            light_levels_t r;
            logic [7:0] s;
            bit ev;
            int len;
            ev = 0;
            len = int'(seq_len);
            if (len < 1) len = 1;
            if (len > LIGHT_DEPTH) len = LIGHT_DEPTH;
            if (step_idx >= LIGHT_DEPTH) step_idx = 0;
            case (cmd)
                CMD_FRAME_BEGIN: begin
                    if (running) begin
                        if (skip_frame) begin
                            skip_frame = 0;
                        end else begin
                            s = lights[step_idx];
                            step_idx++;
                            if (reps == 0) extra = s[BIT_EXTRA];
                            if (out0_mode == OUT_MODE_TABLE) out0 = s[BIT_OUT0];
                            if (out1_mode == OUT_MODE_TABLE) out1 = s[BIT_OUT1];
                            if (s[BIT_STIM]) start_train();
                            if (out0_mode == OUT_MODE_CAMERA) out0 = 1;
                            if (out1_mode == OUT_MODE_CAMERA) out1 = 1;
                            if (evt_src == EVT_SRC_FRAME) ev = 1;
                            if (step_idx >= len) step_idx = 0;
                        end
                    end
                end
                CMD_FRAME_END: begin
                    if (running) begin
                        leds = '0;
                        if (reps == 0) extra = 0;
                        if (out0_mode == OUT_MODE_CAMERA) out0 = 0;
                        if (out1_mode == OUT_MODE_CAMERA) out1 = 0;
                        if (stop_pend) begin
                            stop_pend = 0;
                            running = 0;
                            if (out0_mode == OUT_MODE_TABLE) out0 = 0;
                            if (out1_mode == OUT_MODE_TABLE) out1 = 0;
                        end
                    end
                end
                CMD_LED_ON: begin
                    if (running) leds = leds | lights[step_idx][2:0];
                end
                CMD_STIM_TICK: begin
                    if (stim_run) begin
                        if (extra) begin
                            on_cnt++;
                            if (on_cnt == on_ticks) begin
                                on_cnt = '0;
                                extra = 0;
                            end
                        end
                        per_cnt++;
                        if (per_cnt == per_ticks) begin
                            rep_cnt++;
                            if (rep_cnt == reps || stim_stop_pend) begin
                                stim_run = 0;
                                stim_stop_pend = 0;
                            end else begin
                                per_cnt = '0;
                                extra = 1;
                            end
                        end
                    end
                end
                CMD_STROBE: begin
                    if (out0_mode == OUT_MODE_STROBE) out0 = strobe;
                    if (out1_mode == OUT_MODE_STROBE) out1 = strobe;
                    if (strobe && evt_src == EVT_SRC_STROBE) ev = 1;
                end
                CMD_WRITE_STEP: begin
                    if (int'(slot) < LIGHT_DEPTH) lights[slot] = val;
                end
                CMD_START: begin
                    if (!running) begin
                        running = 1;
                        step_idx = 0;
                        skip_frame = 1;
                        stop_pend = 0;
                    end
                end
                CMD_STOP: begin
                    if (running) stop_pend = 1;
                end
                CMD_STIM_STOP: begin
                    if (stim_run) stim_stop_pend = 1;
                end
                default: ;
            endcase
            r.leds = leds;
            r.extra = extra;
            r.out0 = out0;
            r.out1 = out1;
            r.stim = stim_run;
            r.ev = ev;
            r.word = ev ? {lvl, stim_run, out1, out0, extra, leds} : 8'h00;
            levels_q.push_back(r);
        endfunction

        function int pending();
            return levels_q.size();
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_result(logic [M_TDATA_W-1:0] data, logic [M_TUSER_W-1:0] user);
            light_levels_t e;
            if (levels_q.size() == 0) begin
                report_mismatch($sformatf("result %0h with no item pending", data));
                return;
            end
            e = levels_q.pop_front();
            if (data[2:0] !== e.leds)
                report_mismatch($sformatf("led_levels %0h, want %0h", data[2:0], e.leds));
            if (data[3] !== e.extra)
                report_mismatch($sformatf("extra_level %0b, want %0b", data[3], e.extra));
            if (data[4] !== e.out0)
                report_mismatch($sformatf("out0_level %0b, want %0b", data[4], e.out0));
            if (data[5] !== e.out1)
                report_mismatch($sformatf("out1_level %0b, want %0b", data[5], e.out1));
            if (data[6] !== e.stim)
                report_mismatch($sformatf("stim_active %0b, want %0b", data[6], e.stim));
            if (user[0] !== e.ev)
                report_mismatch($sformatf("event_valid %0b, want %0b", user[0], e.ev));
            if (data[14:7] !== e.word)
                report_mismatch($sformatf("event_word %0h, want %0h", data[14:7], e.word));
        endtask
    endclass

    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    light_scoreboard sb;
    int  burst_left = 0;
    int  items_sent = 0;
    int  cycles = 0;
    bit  hold_req = 1'b0;
    int  hold_left = 0;
    int  rx_left = 0;
    int  rx_mode = 0;

    frame_light_trigger_sequencer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("frame_light_trigger_sequencer_unit verification failed");
            $finish;
        end
    end

    // result side: stall patterns plus an occasional long hold-off
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 150);
        end
        rx_left--;
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= rx_left[0];
            endcase
        end
    end

    task automatic send_item(logic [3:0] cmd, logic strobe, logic lvl,
                             logic [4:0] slot, logic [7:0] val);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {1'b0, val, slot, lvl, strobe};
        do @(posedge aclk); while (!s_tready);
        sb.note_item(cmd, strobe, lvl, slot, val);
        items_sent++;
    endtask

    task automatic send_op(logic [3:0] cmd, logic strobe);
        send_item(cmd, strobe, 1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                  8'($urandom_range(0, 255)));
    endtask

    task automatic send_frame();
        int ticks;
        ticks = $urandom_range(0, 5);
        send_op(CMD_FRAME_BEGIN, 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 3) != 0) send_op(CMD_LED_ON, 1'($urandom_range(0, 1)));
        repeat (ticks) send_op(CMD_STIM_TICK, 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 4) != 0) begin
            send_op(CMD_STROBE, 1'b1);
            send_op(CMD_STROBE, 1'b0);
        end
        send_op(CMD_FRAME_END, 1'($urandom_range(0, 1)));
    endtask

    task automatic run_traffic(int n);
        int target;
        int pick;
        target = items_sent + n;
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) send_op(CMD_START, 1'($urandom_range(0, 1)));
            else if (pick < 12) send_op(CMD_STOP, 1'($urandom_range(0, 1)));
            else if (pick < 15) send_op(CMD_STIM_STOP, 1'($urandom_range(0, 1)));
            else if (pick < 20) send_op(CMD_WRITE_STEP, 1'($urandom_range(0, 1)));
            else if (pick < 25) send_op(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
            else send_frame();
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    task automatic configure(int phase);
        logic [5:0]  len;
        logic [1:0]  m0, m1, src;
        logic [15:0] on_t, per_t, rep_n;
        case (phase)
            0: begin
                len = 6'd3; m0 = OUT_MODE_TABLE; m1 = OUT_MODE_CAMERA; src = EVT_SRC_FRAME;
                on_t = 16'd2; per_t = 16'd3; rep_n = 16'd2;
            end
            1: begin
                len = 6'd1; m0 = OUT_MODE_STROBE; m1 = OUT_MODE_OTHER; src = EVT_SRC_STROBE;
                on_t = 16'd1; per_t = 16'd1; rep_n = 16'hFFFF;
            end
            2: begin
                len = 6'd32; m0 = OUT_MODE_CAMERA; m1 = OUT_MODE_TABLE; src = EVT_SRC_NONE;
                on_t = 16'hFFFF; per_t = 16'hFFFF; rep_n = 16'd0;
            end
            3: begin
                len = 6'd0; m0 = OUT_MODE_OTHER; m1 = OUT_MODE_STROBE; src = EVT_SRC_FRAME;
                on_t = 16'd5; per_t = 16'd8; rep_n = 16'd0;
            end
            4: begin
                len = 6'd63; m0 = OUT_MODE_TABLE; m1 = OUT_MODE_STROBE; src = EVT_SRC_STROBE;
                on_t = 16'd3; per_t = 16'd4; rep_n = 16'd3;
            end
            default: begin
                len = 6'($urandom_range(1, 32));
                m0 = 2'($urandom_range(0, 3));
                m1 = 2'($urandom_range(0, 3));
                src = 2'($urandom_range(0, 2));
                on_t = 16'($urandom_range(1, 12));
                per_t = 16'($urandom_range(1, 16));
                rep_n = 16'($urandom_range(0, 6));
            end
        endcase
        write_reg(CFG_SEQ_LEN, {10'd0, len});
        write_reg(CFG_OUT0_MODE, {14'd0, m0});
        write_reg(CFG_OUT1_MODE, {14'd0, m1});
        write_reg(CFG_EVENT_SRC, {14'd0, src});
        write_reg(CFG_STIM_ON, on_t);
        write_reg(CFG_STIM_PERIOD, per_t);
        write_reg(CFG_STIM_REPEATS, rep_n);
        cfg_we <= 1'b0;
    endtask

    initial begin
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        configure(0);

        // fill every light entry before the sequencer can read one
        for (int i = 0; i < LIGHT_DEPTH; i++)
            send_item(CMD_WRITE_STEP, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      5'(i), (i == 0) ? 8'hFF : (i == 1) ? 8'h00 : 8'($urandom_range(0, 255)));

        // sequencer and train idle
        send_op(CMD_FRAME_BEGIN, 1'b0);
        send_op(CMD_FRAME_END, 1'b0);
        send_op(CMD_LED_ON, 1'b0);
        send_op(CMD_STIM_TICK, 1'b0);
        send_op(CMD_STIM_STOP, 1'b0);
        send_op(CMD_STOP, 1'b0);
        // start, repeated start, swallowed first frame, full entry with train start
        send_op(CMD_START, 1'b0);
        send_op(CMD_START, 1'b1);
        send_op(CMD_FRAME_BEGIN, 1'b0);
        send_item(CMD_FRAME_BEGIN, 1'b0, 1'b1, 5'd0, 8'h00);
        send_op(CMD_LED_ON, 1'b0);
        send_op(CMD_STIM_TICK, 1'b0);
        send_op(CMD_STIM_TICK, 1'b0);
        send_item(CMD_STROBE, 1'b1, 1'b1, 5'd31, 8'hFF);
        send_op(CMD_STROBE, 1'b0);
        send_op(CMD_STIM_STOP, 1'b0);
        send_op(CMD_STIM_TICK, 1'b0);
        send_op(CMD_FRAME_END, 1'b0);
        send_op(CMD_UNUSED_LO, 1'b1);
        send_op(CMD_UNUSED_HI, 1'b0);
        // stop takes effect at the next frame end
        send_op(CMD_STOP, 1'b0);
        send_op(CMD_FRAME_BEGIN, 1'b0);
        send_op(CMD_FRAME_END, 1'b0);
        send_item(CMD_WRITE_STEP, 1'b0, 1'b0, 5'd31, 8'h40);

        for (int p = 1; p < PHASES; p++) begin
            drain();
            configure(p);
            if (p % 3 == 1) hold_req = 1'b1;
            run_traffic(PHASE_ITEMS);
        end

        drain();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("frame_light_trigger_sequencer_unit verification clean");
        end else begin
            $display("frame_light_trigger_sequencer_unit verification failed");
        end
        $finish;
    end

endmodule
